/* design/hrvtd_pkg.sv */
// Shared widths, constants and types of the HRV time-domain window block.
`default_nettype none
package hrvtd_pkg;
   localparam int RR_W          = 12;
   localparam int Q4_W          = 16;
   localparam int CNT_W         = 5;
   localparam logic [RR_W-1:0]  THRESH_RESET = 12'd50;
   localparam logic [RR_W-1:0]  RR_MAX       = 12'hFFF;
   localparam logic [CNT_W-1:0] COUNT_MAX    = 5'd31;

   typedef struct packed {
      logic [RR_W-1:0]  max_rr;
      logic [RR_W-1:0]  min_rr;
      logic [CNT_W-1:0] pnn50_count;
   } hrvtd_stat_type;
endpackage
`default_nettype wire

/* design/hrvtd_if.sv */
// Valid/ready channel interfaces for interval beats and statistics beats.
`default_nettype none
interface hrvtd_req_if;
   logic                        valid;
   logic                        ready;
   logic [hrvtd_pkg::RR_W-1:0]  rr_interval;
   modport source (output valid, output rr_interval, input ready);
   modport sink   (input valid, input rr_interval, output ready);
endinterface

interface hrvtd_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         ready_res;
   logic [hrvtd_pkg::RR_W-1:0]   max_rr;
   logic [hrvtd_pkg::RR_W-1:0]   min_rr;
   logic [hrvtd_pkg::Q4_W-1:0]   mean_rr_q4;
   logic [hrvtd_pkg::Q4_W-1:0]   sdnn_q4;
   logic [hrvtd_pkg::Q4_W-1:0]   rmssd_q4;
   logic [hrvtd_pkg::CNT_W-1:0]  pnn50_count;
   modport source (output valid, output ready_res, output max_rr, output min_rr,
                   output mean_rr_q4, output sdnn_q4, output rmssd_q4,
                   output pnn50_count, input ready);
   modport sink   (input valid, input ready_res, input max_rr, input min_rr,
                   input mean_rr_q4, input sdnn_q4, input rmssd_q4,
                   input pnn50_count, output ready);
endinterface
`default_nettype wire

/* design/hrvtd_window.sv */
// Interval store with serial walk that accumulates window sums, extremes and the pNN50 count.
`default_nettype none
module hrvtd_window #(
   parameter int N  = 32,
   parameter int LW = 6,
   parameter int SW = 18,
   parameter int QW = 30
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          wr_en,
   input  wire logic [hrvtd_pkg::RR_W-1:0]    wr_data,
   input  wire logic [hrvtd_pkg::RR_W-1:0]    thresh,
   input  wire logic                          start,
   output      logic                          full,
   output      logic                          done,
   output      logic [SW-1:0]                 sum,
   output      logic [QW-1:0]                 sumsq,
   output      logic [QW-1:0]                 dsq,
   output      hrvtd_pkg::hrvtd_stat_type     stat
);
   localparam int AW = $clog2(N);
   localparam int RW = hrvtd_pkg::RR_W;

   logic [RW-1:0] mem [N];
   logic [RW-1:0] rd_data_ff, prev_ff;
   logic [AW-1:0] wpos_ff, rd_ptr_ff;
   logic [LW-1:0] fill_ff, left_ff;
   logic          issue_ff, last_ff, first_ff, done_ff;
   logic [SW-1:0] sum_ff;
   logic [QW-1:0] sumsq_ff, dsq_ff;
   hrvtd_pkg::hrvtd_stat_type stat_ff;
   logic [RW-1:0] diff;
   logic [2*RW-1:0] vsq, dsqr;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wpos_ff] <= wr_data;
      end
      rd_data_ff <= mem[rd_ptr_ff];
   end

   always_comb begin
      diff = (rd_data_ff > prev_ff) ? rd_data_ff - prev_ff : prev_ff - rd_data_ff;
      vsq  = rd_data_ff * rd_data_ff;
      dsqr = diff * diff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wpos_ff  <= '0;
         fill_ff  <= '0;
         left_ff  <= '0;
         issue_ff <= 1'b0;
         last_ff  <= 1'b0;
         first_ff <= 1'b0;
         done_ff  <= 1'b0;
         rd_ptr_ff <= '0;
      end else begin
         done_ff <= issue_ff && last_ff;
         if (wr_en) begin
            wpos_ff <= (wpos_ff == AW'(N-1)) ? '0 : wpos_ff + 1'b1;
            if (fill_ff != LW'(N)) begin
               fill_ff <= fill_ff + 1'b1;
            end
         end
         if (start) begin
            rd_ptr_ff <= wpos_ff;
            left_ff   <= LW'(N);
            first_ff  <= 1'b1;
            issue_ff  <= 1'b0;
            last_ff   <= 1'b0;
         end else begin
            issue_ff <= (left_ff != '0);
            last_ff  <= (left_ff == LW'(1));
            if (left_ff != '0) begin
               rd_ptr_ff <= (rd_ptr_ff == AW'(N-1)) ? '0 : rd_ptr_ff + 1'b1;
               left_ff   <= left_ff - 1'b1;
            end
            if (issue_ff) begin
               first_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         sum_ff   <= '0;
         sumsq_ff <= '0;
         dsq_ff   <= '0;
         stat_ff.max_rr      <= '0;
         stat_ff.min_rr      <= hrvtd_pkg::RR_MAX;
         stat_ff.pnn50_count <= '0;
      end else if (issue_ff) begin
         prev_ff  <= rd_data_ff;
         sum_ff   <= sum_ff + SW'(rd_data_ff);
         sumsq_ff <= sumsq_ff + QW'(vsq);
         if (rd_data_ff > stat_ff.max_rr) begin
            stat_ff.max_rr <= rd_data_ff;
         end
         if (rd_data_ff < stat_ff.min_rr) begin
            stat_ff.min_rr <= rd_data_ff;
         end
         if (!first_ff) begin
            dsq_ff <= dsq_ff + QW'(dsqr);
            if (diff > thresh && stat_ff.pnn50_count < hrvtd_pkg::COUNT_MAX) begin
               stat_ff.pnn50_count <= stat_ff.pnn50_count + 1'b1;
            end
         end
      end
   end

   assign full  = (fill_ff == LW'(N));
   assign done  = done_ff;
   assign sum   = sum_ff;
   assign sumsq = sumsq_ff;
   assign dsq   = dsq_ff;
   assign stat  = stat_ff;
endmodule
`default_nettype wire

/* design/hrvtd_div.sv */
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module hrvtd_div #(
   parameter int DW = 40,
   parameter int VW = 12
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [DW-1:0] dividend,
   input  wire logic [VW-1:0] divisor,
   output      logic          done,
   output      logic [DW-1:0] quotient
);
   localparam int CW = $clog2(DW+1);

   logic [DW-1:0] q_ff;
   logic [VW-1:0] rem_ff, dvs_ff;
   logic [CW-1:0] cnt_ff;
   logic          done_ff;
   logic [VW:0]   rem_sh;
   logic          qbit;

   always_comb begin
      rem_sh = {rem_ff, q_ff[DW-1]};
      qbit   = (rem_sh >= {1'b0, dvs_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= (cnt_ff == CW'(1));
         if (start) begin
            cnt_ff <= CW'(DW);
         end else if (cnt_ff != '0) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         q_ff   <= dividend;
         dvs_ff <= divisor;
         rem_ff <= '0;
      end else if (cnt_ff != '0) begin
         rem_ff <= qbit ? VW'(rem_sh - {1'b0, dvs_ff}) : VW'(rem_sh);
         q_ff   <= {q_ff[DW-2:0], qbit};
      end
   end

   assign done     = done_ff;
   assign quotient = q_ff;
endmodule
`default_nettype wire

/* design/hrvtd_sqrt.sv */
// Floor square root, one root bit per cycle.
`default_nettype none
module hrvtd_sqrt #(
   parameter int IW = 40
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            start,
   input  wire logic [IW-1:0]   value,
   output      logic            done,
   output      logic [IW/2-1:0] root
);
   localparam int RW = IW / 2;
   localparam int CW = $clog2(RW+1);

   logic [IW-1:0] val_ff;
   logic [RW-1:0] root_ff;
   logic [RW:0]   rem_ff;
   logic [CW-1:0] cnt_ff;
   logic          done_ff;
   logic [RW+2:0] rem_sh, trial;
   logic          fit;

   always_comb begin
      rem_sh = {rem_ff, val_ff[IW-1:IW-2]};
      trial  = {1'b0, root_ff, 2'b01};
      fit    = (rem_sh >= trial);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= (cnt_ff == CW'(1));
         if (start) begin
            cnt_ff <= CW'(RW);
         end else if (cnt_ff != '0) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         val_ff  <= value;
         root_ff <= '0;
         rem_ff  <= '0;
      end else if (cnt_ff != '0) begin
         val_ff  <= {val_ff[IW-3:0], 2'b00};
         rem_ff  <= fit ? (RW+1)'(rem_sh - trial) : (RW+1)'(rem_sh);
         root_ff <= {root_ff[RW-2:0], fit};
      end
   end

   assign done = done_ff;
   assign root = root_ff;
endmodule
`default_nettype wire

/* design/hrv_time_domain_window_core.sv */
// HRV time-domain window statistics core (top level).
// Usage:
//   req_bus carries one RR interval (ms) per beat; rsp_bus returns exactly one
//   statistics beat per request beat. csr_wr_en/csr_wr_data set the pNN50
//   difference threshold (reset 50 ms); write it only while the core is idle.
//   Until WINDOW_SIZE intervals have been seen, ready_res and all stats are 0;
//   that result goes from the fill check straight to the output register.
//   With a full window the core walks the store one entry a cycle, then
//   runs a shared bit-serial divider three times (D, the dividend width, is
//   50 at N=256 and 44 at N=32) and a bit-serial square root twice, with a
//   root D/2 bits wide; the result then goes to the output register.
//   One item is processed at a time; req_bus.ready is high only when idle.
//   A finished result sits in the output register while the next request
//   is taken; if rsp_bus stalls, the next result waits until it is taken.
//   Reset clears the fill count, write position and valid flags, sets the
//   threshold to 50 ms; store contents are not cleared, only read once written.
`default_nettype none
module hrv_time_domain_window_core #(
   parameter int WINDOW_SIZE = 32
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   hrvtd_req_if.sink                        req_bus,
   hrvtd_rsp_if.source                      rsp_bus,
   input  wire logic                        csr_wr_en,
   input  wire logic [hrvtd_pkg::RR_W-1:0]  csr_wr_data
);
   localparam int N    = WINDOW_SIZE;
   localparam int LW   = $clog2(N+1);
   localparam int SW   = hrvtd_pkg::RR_W + LW;
   localparam int QW   = 2*hrvtd_pkg::RR_W + LW;
   localparam int NUMW = QW + LW;
   localparam int DVW  = NUMW + 8;
   localparam int VW   = 2*LW;
   localparam int IW   = DVW + (DVW % 2);
   localparam int Q4   = hrvtd_pkg::Q4_W;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_CHECK = 4'd1;
   localparam logic [3:0] S_WALK  = 4'd2;
   localparam logic [3:0] S_MEAN  = 4'd3;
   localparam logic [3:0] S_SDDIV = 4'd4;
   localparam logic [3:0] S_SDSQ  = 4'd5;
   localparam logic [3:0] S_RMDIV = 4'd6;
   localparam logic [3:0] S_RMSQ  = 4'd7;
   localparam logic [3:0] S_OUT   = 4'd8;

   logic [3:0]               state_ff, state_in;
   logic [hrvtd_pkg::RR_W-1:0] thresh_ff;
   logic                     req_fire, full, walk_start, walk_done;
   logic [SW-1:0]            sum;
   logic [QW-1:0]            sumsq, dsq;
   hrvtd_pkg::hrvtd_stat_type stat;
   logic [NUMW-1:0]          num_ff;
   logic                     ok_ff, ok_in;
   logic [Q4-1:0]            mean_ff, sdnn_ff, rmssd_ff;
   logic                     div_start, div_done, sq_start, sq_done;
   logic [DVW-1:0]           div_dividend, quotient;
   logic [VW-1:0]            div_divisor;
   logic [IW/2-1:0]          root;
   logic                     rsp_valid_ff, load;

   assign req_fire      = req_bus.valid && req_bus.ready;
   assign req_bus.ready = (state_ff == S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= hrvtd_pkg::THRESH_RESET;
      end else if (csr_wr_en) begin
         thresh_ff <= csr_wr_data;
      end
   end

   hrvtd_window #(.N(N), .LW(LW), .SW(SW), .QW(QW)) u_window (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (req_fire),
      .wr_data (req_bus.rr_interval),
      .thresh  (thresh_ff),
      .start   (walk_start),
      .full    (full),
      .done    (walk_done),
      .sum     (sum),
      .sumsq   (sumsq),
      .dsq     (dsq),
      .stat    (stat)
   );

   hrvtd_div #(.DW(DVW), .VW(VW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (quotient)
   );

   hrvtd_sqrt #(.IW(IW)) u_sqrt (
      .clock (clock),
      .reset (reset),
      .start (sq_start),
      .value (IW'(quotient)),
      .done  (sq_done),
      .root  (root)
   );

   always_ff @(posedge clock) begin
      num_ff <= NUMW'(sumsq) * NUMW'(N) - NUMW'(sum) * NUMW'(sum);
   end

   assign load = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_bus.ready);

   always_comb begin
      state_in     = state_ff;
      ok_in        = ok_ff;
      walk_start   = 1'b0;
      div_start    = 1'b0;
      sq_start     = 1'b0;
      div_dividend = DVW'(sum) << 4;
      div_divisor  = VW'(N);
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            ok_in = full;
            if (full) begin
               walk_start = 1'b1;
               state_in   = S_WALK;
            end else begin
               state_in = S_OUT;
            end
         end
         S_WALK: begin
            if (walk_done) begin
               div_start = 1'b1;
               state_in  = S_MEAN;
            end
         end
         S_MEAN: begin
            div_dividend = DVW'(num_ff) << 8;
            div_divisor  = VW'(N * N);
            if (div_done) begin
               div_start = 1'b1;
               state_in  = S_SDDIV;
            end
         end
         S_SDDIV: begin
            if (div_done) begin
               sq_start = 1'b1;
               state_in = S_SDSQ;
            end
         end
         S_SDSQ: begin
            div_dividend = DVW'(dsq) << 8;
            div_divisor  = VW'(N - 1);
            if (sq_done) begin
               div_start = 1'b1;
               state_in  = S_RMDIV;
            end
         end
         S_RMDIV: begin
            if (div_done) begin
               sq_start = 1'b1;
               state_in = S_RMSQ;
            end
         end
         S_RMSQ: begin
            if (sq_done) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ok_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ok_ff    <= ok_in;
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_MEAN && div_done) begin
         mean_ff <= quotient[Q4-1:0];
      end
      if (state_ff == S_SDSQ && sq_done) begin
         sdnn_ff <= root[Q4-1:0];
      end
      if (state_ff == S_RMSQ && sq_done) begin
         rmssd_ff <= root[Q4-1:0];
      end
      if (load) begin
         rsp_bus.ready_res   <= ok_ff;
         rsp_bus.max_rr      <= ok_ff ? stat.max_rr : '0;
         rsp_bus.min_rr      <= ok_ff ? stat.min_rr : '0;
         rsp_bus.pnn50_count <= ok_ff ? stat.pnn50_count : '0;
         rsp_bus.mean_rr_q4  <= ok_ff ? mean_ff : '0;
         rsp_bus.sdnn_q4     <= ok_ff ? sdnn_ff : '0;
         rsp_bus.rmssd_q4    <= ok_ff ? rmssd_ff : '0;
      end
   end

   assign rsp_bus.valid = rsp_valid_ff;
endmodule
`default_nettype wire
